@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL, included by arm_dp_statement_assembler.
// Each macro expands to one labeled concurrent assertion on the rising clock
// edge, disabled while the synchronous active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is never true out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

@@ hw/rtl/dpsa_pkg.sv @@
// ----------------------------------------------------------------------------
// dpsa_pkg
// Types, codes and the immediate encoder shared by the statement assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package dpsa_pkg;

  // Token classes from the lexer
  typedef enum logic [2:0] {
    TK_MNEM  = 3'd0,
    TK_REG   = 3'd1,
    TK_COMMA = 3'd2,
    TK_HASH  = 3'd3,
    TK_CONST = 3'd4,
    TK_SHIFT = 3'd5,
    TK_END   = 3'd6,
    TK_OTHER = 3'd7
  } tok_kind_t;

  // Shift keyword codes
  typedef enum logic [2:0] {
    SH_LSL = 3'd0,
    SH_LSR = 3'd1,
    SH_ASR = 3'd2,
    SH_ROR = 3'd3,
    SH_RRX = 3'd4
  } shift_code_t;

  // Result error codes
  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_CMD    = 3'd1,
    ERR_SYNTAX = 3'd2,
    ERR_SHIFT  = 3'd3,
    ERR_CONST  = 3'd4
  } err_t;

  // Parser positions
  typedef enum logic [3:0] {
    POS_MNEM     = 4'd0,
    POS_RD       = 4'd1,
    POS_COMMA1   = 4'd2,
    POS_RN       = 4'd3,
    POS_COMMA2   = 4'd4,
    POS_OPER2    = 4'd5,
    POS_IMMCONST = 4'd6,
    POS_END      = 4'd7,
    POS_AFTER_RM = 4'd8,
    POS_SHIFTKW  = 4'd9,
    POS_SHIFTARG = 4'd10,
    POS_SHIFTAMT = 4'd11
  } parse_pos_t;

  localparam logic [3:0]  MNEM_LAST = 4'd6;
  localparam logic [3:0]  COND_AL   = 4'hE;
  localparam logic [31:0] AMT_MAX   = 32'd32;
  localparam logic [31:0] IMM_MASK  = 32'hFFFF_FF00;

  // Input item
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  mnemonic_code;
    logic        sets_flags;
    logic [3:0]  reg_num;
    logic [2:0]  shift_code;
    logic [31:0] constant_value;
  } dpsa_in_t;

  // Result item
  typedef struct packed {
    logic [31:0] instruction_word;
    logic [2:0]  error_code;
  } dpsa_out_t;

  // Classified token handed from front to back
  typedef struct packed {
    tok_kind_t   kind;
    logic        mnem_ok;
    logic [2:0]  opcode;
    logic        sets_flags;
    logic [3:0]  reg_num;
    logic [2:0]  shift_code;
    logic        shift_ok;
    logic        imm_fits;
    logic [11:0] imm_field;
    logic        amt_over;
    logic        amt_is_max;
    logic        amt_zero;
    logic [4:0]  amt_low;
  } tok_t;

  typedef struct packed {
    logic        fits;
    logic [11:0] field;
  } imm_enc_t;

  // Find the smallest even left rotation that brings the value into 8 bits
  function automatic imm_enc_t encode_imm(input logic [31:0] v);
    imm_enc_t    res;
    logic [31:0] x;
    res.fits  = 1'b0;
    res.field = '0;
    for (int r = 15; r >= 0; r--) begin
      x = (v << (2 * r)) | (v >> (32 - 2 * r));
      if ((x & IMM_MASK) == '0) begin
        res.fits  = 1'b1;
        res.field = {4'(r), x[7:0]};
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/arm_dp_statement_assembler.sv @@
// ----------------------------------------------------------------------------
// arm_dp_statement_assembler
// Assembles ARM data-processing statements from a stream of lexed tokens.
// ----------------------------------------------------------------------------
// The block takes one token per cycle and parses "MNEM rd, rn, oper2" for
// AND, EOR, SUB, RSB, ADD, ADC and SBC with optional S, where oper2 is an
// immediate or a register with an optional shift. On the END token it
// returns one 32-bit instruction word with condition AL; on the first error
// it returns one item carrying the error code and a zero word, and then
// swallows every further token without a result until reset. Tokens that do
// not close a statement give no result. A token is classified in the cycle it
// is accepted (the immediate encoder tries all sixteen rotations at once),
// waits in a two-entry queue and is parsed from there; the result is offered
// from an output register that the parser loads when it takes the END token.
// The parser consumes one token per cycle, so the sustained rate is
// one token per cycle while results are taken as they appear. A result that
// waits on the output holds the parser, and the input stalls once the queue
// holds two tokens.
`default_nettype none

module arm_dp_statement_assembler (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  dpsa_pkg::dpsa_in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dpsa_pkg::dpsa_out_t out_data
);
  import dpsa_pkg::*;

  `include "assert_macros.svh"

  tok_t       front_tok;
  tok_t       head_tok;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;
  logic [1:0] q_count;
  logic       halted;

  // Classify the incoming token
  dpsa_front u_front (
    .in_data (in_data),
    .tok     (front_tok)
  );

  assign in_ready = !q_full;

  // Decouple classification from parsing
  dpsa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready),
    .push_tok  (front_tok),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_tok  (head_tok),
    .count     (q_count)
  );

  // Parse and produce results
  dpsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_tok     (head_tok),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .halted    (halted)
  );

  `ASSERT_CLK(a_err_word_zero, clk, rst_n,
              (out_valid && out_data.error_code != ERR_NONE) |->
              (out_data.instruction_word == '0),
              "error result carries a nonzero word")

  `ASSERT_CLK(a_ok_word_al, clk, rst_n,
              (out_valid && out_data.error_code == ERR_NONE) |->
              (out_data.instruction_word[31:26] == {COND_AL, 2'b00}),
              "assembled word lacks AL data-processing prefix")

  `ASSERT_CLK(a_halted_silent, clk, rst_n,
              (halted && !out_valid) |=> !out_valid,
              "result produced after halt")

  `ASSERT_NEVER(a_queue_overflow, clk, rst_n,
                (q_count == 2'd2) && !q_pop && $past(q_count) == 2'd2 && in_ready,
                "queue full but input ready")

endmodule

`default_nettype wire

@@ hw/rtl/dpsa_front.sv @@
// ----------------------------------------------------------------------------
// dpsa_front
// Classifies one raw token: mnemonic range, shift code range, immediate
// encoding and shift amount range, ready for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsa_front (
  input  dpsa_pkg::dpsa_in_t in_data,
  output dpsa_pkg::tok_t     tok
);
  import dpsa_pkg::*;

  imm_enc_t enc;

  // Encode the constant as a rotated immediate
  assign enc = encode_imm(in_data.constant_value);

  // Pack the classified fields
  always_comb begin
    tok.kind       = tok_kind_t'(in_data.kind);
    tok.mnem_ok    = in_data.mnemonic_code <= MNEM_LAST;
    tok.opcode     = in_data.mnemonic_code[2:0];
    tok.sets_flags = in_data.sets_flags;
    tok.reg_num    = in_data.reg_num;
    tok.shift_code = in_data.shift_code;
    tok.shift_ok   = in_data.shift_code <= SH_RRX;
    tok.imm_fits   = enc.fits;
    tok.imm_field  = enc.field;
    tok.amt_over   = in_data.constant_value > AMT_MAX;
    tok.amt_is_max = in_data.constant_value == AMT_MAX;
    tok.amt_zero   = in_data.constant_value == '0;
    tok.amt_low    = in_data.constant_value[4:0];
  end

endmodule

`default_nettype wire

@@ hw/rtl/dpsa_queue.sv @@
// ----------------------------------------------------------------------------
// dpsa_queue
// Two-entry queue of classified tokens between the front and the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsa_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  dpsa_pkg::tok_t      push_tok,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output dpsa_pkg::tok_t      head_tok,
  output logic [1:0]          count
);
  import dpsa_pkg::*;

  localparam int DEPTH = 2;

  tok_t       slot_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = count_r == 2'(DEPTH);
  assign not_empty = count_r != '0;
  assign head_tok  = slot_r[rd_ptr_r];
  assign count     = count_r;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming token
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dpsa_back.sv @@
// ----------------------------------------------------------------------------
// dpsa_back
// Statement parser: walks the grammar one token at a time, collects the
// instruction fields and loads the output register with a word or an error.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsa_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  dpsa_pkg::tok_t       q_tok,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dpsa_pkg::dpsa_out_t  out_data,
  output logic                 halted
);
  import dpsa_pkg::*;

  parse_pos_t  pos_r, pos_nxt;
  logic        halted_r, halted_nxt;
  logic        out_valid_r, out_valid_nxt;
  dpsa_out_t   out_data_r, out_data_nxt;
  logic [2:0]  opcode_r, opcode_nxt;
  logic        sflag_r, sflag_nxt;
  logic [3:0]  rd_r, rd_nxt;
  logic [3:0]  rn_r, rn_nxt;
  logic [3:0]  rm_r, rm_nxt;
  logic [1:0]  shk_r, shk_nxt;
  logic        imm_r, imm_nxt;
  logic [11:0] oper_r, oper_nxt;

  logic        take;
  err_t        err;
  logic        emit;
  logic [1:0]  amt_kind;

  // Drop tokens while halted; otherwise take one when the output has room
  assign q_pop = q_valid && (halted_r || !out_valid_r || out_ready);
  assign take  = q_pop && !halted_r;

  // Next position, error and emit decision
  always_comb begin
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    err        = ERR_NONE;
    emit       = 1'b0;
    if (take) begin
      case (pos_r)
        POS_MNEM: begin
          if (q_tok.kind != TK_MNEM || !q_tok.mnem_ok) err = ERR_CMD;
          else pos_nxt = POS_RD;
        end
        POS_RD: begin
          if (q_tok.kind != TK_REG) err = ERR_SYNTAX;
          else pos_nxt = POS_COMMA1;
        end
        POS_COMMA1: begin
          if (q_tok.kind != TK_COMMA) err = ERR_SYNTAX;
          else pos_nxt = POS_RN;
        end
        POS_RN: begin
          if (q_tok.kind != TK_REG) err = ERR_SYNTAX;
          else pos_nxt = POS_COMMA2;
        end
        POS_COMMA2: begin
          if (q_tok.kind != TK_COMMA) err = ERR_SYNTAX;
          else pos_nxt = POS_OPER2;
        end
        POS_OPER2: begin
          if (q_tok.kind == TK_HASH) pos_nxt = POS_IMMCONST;
          else if (q_tok.kind == TK_REG) pos_nxt = POS_AFTER_RM;
          else err = ERR_SYNTAX;
        end
        POS_IMMCONST: begin
          if (q_tok.kind != TK_CONST) err = ERR_SYNTAX;
          else if (!q_tok.imm_fits) err = ERR_CONST;
          else pos_nxt = POS_END;
        end
        POS_END: begin
          if (q_tok.kind != TK_END) err = ERR_SYNTAX;
          else begin
            emit    = 1'b1;
            pos_nxt = POS_MNEM;
          end
        end
        POS_AFTER_RM: begin
          if (q_tok.kind == TK_COMMA) pos_nxt = POS_SHIFTKW;
          else if (q_tok.kind == TK_END) begin
            emit    = 1'b1;
            pos_nxt = POS_MNEM;
          end else err = ERR_SYNTAX;
        end
        POS_SHIFTKW: begin
          if (q_tok.kind != TK_SHIFT || !q_tok.shift_ok) err = ERR_SYNTAX;
          else if (q_tok.shift_code == SH_RRX) pos_nxt = POS_END;
          else pos_nxt = POS_SHIFTARG;
        end
        POS_SHIFTARG: begin
          if (q_tok.kind == TK_HASH) pos_nxt = POS_SHIFTAMT;
          else if (q_tok.kind == TK_REG) pos_nxt = POS_END;
          else err = ERR_SYNTAX;
        end
        POS_SHIFTAMT: begin
          if (q_tok.kind != TK_CONST) err = ERR_SYNTAX;
          else if (q_tok.amt_over ||
                   (q_tok.amt_is_max && shk_r != 2'(SH_LSR) && shk_r != 2'(SH_ASR)))
            err = ERR_SHIFT;
          else pos_nxt = POS_END;
        end
        default: err = ERR_SYNTAX;
      endcase
      if (err != ERR_NONE) halted_nxt = 1'b1;
    end
  end

  assign amt_kind = q_tok.amt_zero ? 2'(SH_LSL) : shk_r;

  // Collect fields and build the result
  always_comb begin
    opcode_nxt    = opcode_r;
    sflag_nxt     = sflag_r;
    rd_nxt        = rd_r;
    rn_nxt        = rn_r;
    rm_nxt        = rm_r;
    shk_nxt       = shk_r;
    imm_nxt       = imm_r;
    oper_nxt      = oper_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (take && err == ERR_NONE) begin
      case (pos_r)
        POS_MNEM: begin
          opcode_nxt = q_tok.opcode;
          sflag_nxt  = q_tok.sets_flags;
        end
        POS_RD:       rd_nxt = q_tok.reg_num;
        POS_RN:       rn_nxt = q_tok.reg_num;
        POS_OPER2: begin
          imm_nxt = q_tok.kind == TK_HASH;
          if (q_tok.kind == TK_REG) begin
            rm_nxt   = q_tok.reg_num;
            oper_nxt = {8'h00, q_tok.reg_num};
          end
        end
        POS_IMMCONST: oper_nxt = q_tok.imm_field;
        POS_AFTER_RM: begin
          if (q_tok.kind == TK_END) oper_nxt = {8'h00, rm_r};
        end
        POS_SHIFTKW: begin
          if (q_tok.shift_code == SH_RRX) begin
            shk_nxt  = 2'(SH_ROR);
            oper_nxt = {5'b00000, 2'(SH_ROR), 1'b0, rm_r};
          end else begin
            shk_nxt = q_tok.shift_code[1:0];
          end
        end
        POS_SHIFTARG: begin
          if (q_tok.kind == TK_REG) oper_nxt = {q_tok.reg_num, 1'b0, shk_r, 1'b1, rm_r};
        end
        POS_SHIFTAMT: begin
          shk_nxt  = amt_kind;
          oper_nxt = {q_tok.amt_low, amt_kind, 1'b0, rm_r};
        end
        default: ;
      endcase
    end
    // Load the output register on a word or an error
    if (emit) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.error_code       = ERR_NONE;
      out_data_nxt.instruction_word = {COND_AL, 2'b00, imm_r, 1'b0, opcode_r, sflag_r,
                                       rn_r, rd_r, oper_nxt};
    end else if (take && err != ERR_NONE) begin
      out_valid_nxt                 = 1'b1;
      out_data_nxt.error_code       = err;
      out_data_nxt.instruction_word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_MNEM;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold statement fields and the result payload
  always_ff @(posedge clk) begin
    opcode_r   <= opcode_nxt;
    sflag_r    <= sflag_nxt;
    rd_r       <= rd_nxt;
    rn_r       <= rn_nxt;
    rm_r       <= rm_nxt;
    shk_r      <= shk_nxt;
    imm_r      <= imm_nxt;
    oper_r     <= oper_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign halted    = halted_r;

endmodule

`default_nettype wire
